// ===== src/cpr_pkg.sv =====
package cpr_pkg;

  // Fixed field widths of the stream and configuration ports.
  localparam int unsigned PageW      = 16;
  localparam int unsigned FrameW     = 4;
  localparam int unsigned CountW     = 16;
  localparam int unsigned CfgW       = 5;
  localparam int unsigned InDataW    = 16;
  localparam int unsigned OutDataW   = 40;

  // Bit positions of the result fields inside the master tdata word.
  localparam int unsigned OutFrameLsb = 0;
  localparam int unsigned OutEvvBit   = 4;
  localparam int unsigned OutEvpLsb   = 5;
  localparam int unsigned OutCntLsb   = 21;
  localparam int unsigned OutPadLsb   = 37;

  // Reset value of the active frame count and saturation limit of the fault counter.
  localparam logic [CfgW-1:0]   CfgActiveReset = 5'd16;
  localparam logic [CountW-1:0] FaultMax       = 16'hFFFF;

  // Defaults for the top-level parameters.
  localparam int unsigned FramesDef   = 16;
  localparam int unsigned PageBitsDef = 16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the incoming reference
    logic commit;  // update the frame table and load the result register
  } cmd_t;

endpackage

// ===== src/cpr_ctrl.sv =====
module cpr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cpr_pkg::cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_CALC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // The reference is taken in idle and resolved in the calc state, once
  // the result register is free or being drained.
  always_comb begin
    cmd_o.load   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.commit = (state_q == S_CALC) && (!out_valid_q || out_ready_i);
    state_d      = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        if (cmd_o.commit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // State and the result-valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== src/cpr_dp.sv =====
module cpr_dp #(
  parameter int unsigned FRAMES    = cpr_pkg::FramesDef,
  parameter int unsigned PAGE_BITS = cpr_pkg::PageBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cpr_pkg::cmd_t               cmd_i,
  input  logic [cpr_pkg::PageW-1:0]   page_i,
  input  logic                        last_i,
  input  logic                        cfg_we_i,
  input  logic [cpr_pkg::CfgW-1:0]    cfg_wdata_i,
  output logic                        hit_o,
  output logic [cpr_pkg::FrameW-1:0]  frame_o,
  output logic                        evicted_valid_o,
  output logic [cpr_pkg::PageW-1:0]   evicted_page_o,
  output logic [cpr_pkg::CountW-1:0]  fault_count_o
);

  localparam int unsigned IdxW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CntW = $clog2(FRAMES + 1);

  // Frame table and run state.
  logic [PAGE_BITS-1:0]       pages_q [FRAMES];
  logic [FRAMES-1:0]          valid_q, valid_d;
  logic [FRAMES-1:0]          use_q, use_d;
  logic [IdxW-1:0]            hand_q, hand_d;
  logic [cpr_pkg::CountW-1:0] faults_q, faults_d;
  logic [cpr_pkg::CfgW-1:0]   active_q;

  // Captured reference.
  logic [PAGE_BITS-1:0] page_q;
  logic                 last_q;

  // Result register.
  logic                        out_hit_q;
  logic [cpr_pkg::FrameW-1:0]  out_frame_q;
  logic                        out_evv_q;
  logic [cpr_pkg::PageW-1:0]   out_evp_q;
  logic [cpr_pkg::CountW-1:0]  out_cnt_q;

  logic [31:0]          page_ext;
  logic [CntW-1:0]      n_act;
  logic [FRAMES-1:0]    in_range;
  logic [FRAMES-1:0]    match_vec;
  logic [FRAMES-1:0]    clr_vec;
  logic [FRAMES-1:0]    upper_vec;
  logic [FRAMES-1:0]    sweep_mask;
  logic                 hit;
  logic [IdxW-1:0]      hit_idx;
  logic [IdxW-1:0]      hand_eff;
  logic [IdxW-1:0]      upper_idx;
  logic [IdxW-1:0]      clr_idx;
  logic [IdxW-1:0]      victim;
  logic [CntW-1:0]      victim_inc;
  logic [IdxW-1:0]      slot;
  logic [31:0]          slot_ext;
  logic [31:0]          evp_ext;
  logic                 evv;

  assign page_ext = {16'b0, page_i};

  // Active frame count, clamped to one through FRAMES.
  always_comb begin
    if (active_q == '0) begin
      n_act = CntW'(1);
    end else if (32'(active_q) > 32'(FRAMES)) begin
      n_act = CntW'(FRAMES);
    end else begin
      n_act = CntW'(active_q);
    end
  end

  // The hand restarts at frame zero when the active count was lowered to or below it.
  assign hand_eff = (32'(hand_q) >= 32'(n_act)) ? '0 : hand_q;

  // Parallel tag match and the candidate vectors for the victim search.
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      in_range[i]  = (i < int'(n_act));
      match_vec[i] = valid_q[i] && in_range[i] && (pages_q[i] == page_q);
      clr_vec[i]   = !use_q[i] && in_range[i];
      upper_vec[i] = clr_vec[i] && (i >= int'(hand_eff));
    end
  end

  // Lowest-numbered match, and first clear use bit at or after the hand and overall.
  always_comb begin
    hit_idx   = '0;
    upper_idx = '0;
    clr_idx   = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        hit_idx = IdxW'(i);
      end
      if (upper_vec[i]) begin
        upper_idx = IdxW'(i);
      end
      if (clr_vec[i]) begin
        clr_idx = IdxW'(i);
      end
    end
  end

  assign hit = |match_vec;

  // Victim choice: wrap around when nothing clear lies ahead of the hand; when
  // every active use bit is set, the sweep comes full circle to the hand.
  always_comb begin
    priority if (|upper_vec) begin
      victim = upper_idx;
    end else if (|clr_vec) begin
      victim = clr_idx;
    end else begin
      victim = hand_eff;
    end
  end

  // Use bits passed by the sweep, which it clears.
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      if (!(|clr_vec)) begin
        sweep_mask[i] = in_range[i];
      end else if (victim >= hand_eff) begin
        sweep_mask[i] = (i >= int'(hand_eff)) && (i < int'(victim));
      end else begin
        sweep_mask[i] = in_range[i] && ((i >= int'(hand_eff)) || (i < int'(victim)));
      end
    end
  end

  assign victim_inc = CntW'(victim) + CntW'(1);
  assign slot       = hit ? hit_idx : victim;
  assign slot_ext   = 32'(slot);
  assign evv        = !hit && valid_q[victim];
  assign evp_ext    = evv ? 32'(pages_q[victim]) : 32'd0;

  // Next run state for a committed reference; a last reference ends the run.
  always_comb begin
    valid_d  = valid_q;
    use_d    = use_q;
    hand_d   = hand_q;
    faults_d = faults_q;
    if (hit) begin
      use_d[hit_idx] = 1'b1;
    end else begin
      use_d          = use_q & ~sweep_mask;
      use_d[victim]  = 1'b1;
      valid_d[victim] = 1'b1;
      hand_d         = (victim_inc == n_act) ? '0 : IdxW'(victim_inc);
      if (faults_q != cpr_pkg::FaultMax) begin
        faults_d = faults_q + cpr_pkg::CountW'(1);
      end
    end
  end

  // Control state of the run and the configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      use_q    <= '0;
      hand_q   <= '0;
      faults_q <= '0;
      active_q <= cpr_pkg::CfgActiveReset;
    end else begin
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
      if (cmd_i.commit) begin
        if (last_q) begin
          valid_q  <= '0;
          use_q    <= '0;
          hand_q   <= '0;
          faults_q <= '0;
        end else begin
          valid_q  <= valid_d;
          use_q    <= use_d;
          hand_q   <= hand_d;
          faults_q <= faults_d;
        end
      end
    end
  end

  // Page store: written into the victim frame on a fault.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !hit) begin
      pages_q[victim] <= page_q;
    end
  end

  // Captured reference and the result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      page_q <= page_ext[PAGE_BITS-1:0];
      last_q <= last_i;
    end
    if (cmd_i.commit) begin
      out_hit_q   <= hit;
      out_frame_q <= slot_ext[cpr_pkg::FrameW-1:0];
      out_evv_q   <= evv;
      out_evp_q   <= evp_ext[cpr_pkg::PageW-1:0];
      out_cnt_q   <= faults_d;
    end
  end

  assign hit_o           = out_hit_q;
  assign frame_o         = out_frame_q;
  assign evicted_valid_o = out_evv_q;
  assign evicted_page_o  = out_evp_q;
  assign fault_count_o   = out_cnt_q;

endmodule

// ===== src/clock_page_replacement.sv =====
// Clock (second-chance) page replacement, one page reference per transfer.
// A reference is captured in idle and then resolved by the tag match and victim
// search in the calc state; no new reference is taken before that, and a result
// held by the receiver holds back the next one.
// Reset (rst_ni low, asynchronous) clears all valid and use bits, the hand, the
// fault count and the result flag and sets active_frames to 16; page tags are not cleared.
module clock_page_replacement #(
  parameter int unsigned FRAMES    = cpr_pkg::FramesDef,
  parameter int unsigned PAGE_BITS = cpr_pkg::PageBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tdata: page [15:0]
  input  logic [cpr_pkg::InDataW-1:0]   s_axis_tdata_i,
  input  logic                          s_axis_tlast_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tdata: frame [3:0], evicted_valid [4], evicted_page [20:5],
  // fault_count [36:21], zero fill [39:37]
  output logic [cpr_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // tuser: hit [0]
  output logic                          m_axis_tuser_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  input  logic                          cfg_we_i,
  input  logic [cpr_pkg::CfgW-1:0]      cfg_wdata_i
);

  cpr_pkg::cmd_t               cmd;
  logic                        hit;
  logic [cpr_pkg::FrameW-1:0]  frame;
  logic                        evicted_valid;
  logic [cpr_pkg::PageW-1:0]   evicted_page;
  logic [cpr_pkg::CountW-1:0]  fault_count;

  cpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  cpr_dp #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .page_i          (s_axis_tdata_i),
    .last_i          (s_axis_tlast_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .hit_o           (hit),
    .frame_o         (frame),
    .evicted_valid_o (evicted_valid),
    .evicted_page_o  (evicted_page),
    .fault_count_o   (fault_count)
  );

  // Pack the result fields, lowest field first.
  assign m_axis_tdata_o = {3'b000, fault_count, evicted_page, evicted_valid, frame};
  assign m_axis_tuser_o = hit;

endmodule

// ===== src/cpr_checker.sv =====
module cpr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic [cpr_pkg::InDataW-1:0]   s_axis_tdata_i,
  input logic                          s_axis_tlast_i,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic [cpr_pkg::OutDataW-1:0]  m_axis_tdata_o,
  input logic                          m_axis_tuser_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic                          cfg_we_i,
  input logic [cpr_pkg::CfgW-1:0]      cfg_wdata_i
);

  // A reference is resolved before the next one is taken.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted twice in a row");

  // A new result appears only after a reference was taken and held.
  a_result_follows_ref: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result without a pending reference");

  // A hit never reports an eviction.
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> !m_axis_tdata_o[cpr_pkg::OutEvvBit])
    else $error("eviction reported on a hit");

  // A stalled result holds.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

endmodule

bind clock_page_replacement cpr_checker u_cpr_checker (.*);
